### src/pot_change_gate_to_cc_unit_macros.svh
// Assertion macros for the pot change gate block.
`ifndef POT_CHANGE_GATE_TO_CC_UNIT_MACROS_SVH
`define POT_CHANGE_GATE_TO_CC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcg: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcg: next-cycle check failed");
`else
`define PCG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/pcg_pkg.sv
// Shared types, constants and the sample scaling function of the pot change gate.
package pcg_pkg;

    // A 5-bit pot index reaches at most this many pots
    localparam int MAX_POTS   = 32;
    localparam int SAMPLE_FULL = 1023;
    localparam int CC_FULL     = 127;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_TIMEOUT   = 2'd1,
        CFG_CHANNEL   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]  pot_index;
        logic [9:0]  sample;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [4:0] out_index;
        logic [6:0] cc_value;
        logic [4:0] out_channel;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  threshold;
        logic [15:0] timeout;
        logic [4:0]  channel;
    } t_cfg;

    typedef struct packed {
        logic [9:0]  raw;
        logic [6:0]  scaled;
        logic [31:0] move_time;
    } t_pot_state;

    typedef struct packed {
        logic        sent_we;
        logic        move_we;
        logic [9:0]  raw;
        logic [6:0]  scaled;
        logic [31:0] move_time;
    } t_state_wr;

    typedef struct packed {
        logic       emit;
        logic       move;
        logic [6:0] scaled;
    } t_eval;

    // floor(raw*127/1023): estimate with >>10, then one correction step
    function automatic logic [6:0] pcg_scale(input logic [9:0] raw);
        logic [16:0] prod;
        logic [6:0]  q0;
        logic [10:0] rem;
        prod = 17'(raw) * 17'(CC_FULL);
        q0   = prod[16:10];
        rem  = {1'b0, prod[9:0]} + {4'b0, q0};
        return (rem >= 11'(SAMPLE_FULL)) ? q0 + 7'd1 : q0;
    endfunction

endpackage

### src/pcg_stream_if.sv
// Valid/ready stream interface carrying one request per handshake.
interface pcg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/pcg_cfg_regs.sv
// Configuration register file: threshold, motion timeout and MIDI channel.
module pcg_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output pcg_pkg::t_cfg                   o_cfg
);
    import pcg_pkg::*;

    logic [9:0]  r_threshold;
    logic [15:0] r_timeout;
    logic [4:0]  r_channel;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 10'd10;
            r_timeout   <= 16'd300;
            r_channel   <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[9:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata[15:0];
                CFG_CHANNEL:   r_channel   <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = '{threshold: r_threshold, timeout: r_timeout, channel: r_channel};

endmodule

### src/pcg_state_store.sv
// Per-pot state table: last sent raw and scaled values and last-move time.
module pcg_state_store #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_idx,
    input  pcg_pkg::t_state_wr   i_wr,
    output pcg_pkg::t_pot_state  o_rd
);
    import pcg_pkg::*;

    logic [9:0]  r_raw       [DEPTH];
    logic [6:0]  r_scaled    [DEPTH];
    logic [31:0] r_move_time [DEPTH];

    // Read the addressed pot
    assign o_rd = '{raw: r_raw[i_idx], scaled: r_scaled[i_idx],
                    move_time: r_move_time[i_idx]};

    // Update the addressed pot; everything clears at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_raw[k]       <= '0;
                r_scaled[k]    <= '0;
                r_move_time[k] <= '0;
            end
        end else begin
            if (i_wr.sent_we) begin
                r_raw[i_idx]    <= i_wr.raw;
                r_scaled[i_idx] <= i_wr.scaled;
            end
            if (i_wr.move_we) begin
                r_move_time[i_idx] <= i_wr.move_time;
            end
        end
    end

endmodule

### src/pcg_eval.sv
// Gate decision for one sample: scaling, jitter threshold and motion window.
module pcg_eval (
    input  pcg_pkg::t_in_item    i_item,
    input  pcg_pkg::t_pot_state  i_state,
    input  pcg_pkg::t_cfg        i_cfg,
    output pcg_pkg::t_eval       o_res
);
    import pcg_pkg::*;

    logic [6:0]  scaled;
    logic [9:0]  diff;
    logic        move;
    logic [31:0] move_time;
    logic [31:0] elapsed;
    logic        moving;

    // Scaling, absolute raw difference against the last sent value and motion window
    always_comb begin
        scaled    = pcg_scale(i_item.sample);
        diff      = (i_item.sample >= i_state.raw) ? i_item.sample - i_state.raw
                                                   : i_state.raw - i_item.sample;
        move      = diff > i_cfg.threshold;
        move_time = move ? i_item.now_ms : i_state.move_time;
        elapsed   = i_item.now_ms - move_time;
        moving    = elapsed < {16'b0, i_cfg.timeout};
    end

    assign o_res = '{emit: moving && (scaled != i_state.scaled), move: move, scaled: scaled};

endmodule

### src/pot_change_gate_to_cc_unit.sv
// Top level of the pot change gate: input stage, state update and result register.
//
// Takes one pot sample per cycle unless the input stage stalls, and emits a
// control-change request when the pot is within its motion window and its 7-bit
// value changed. A sample is registered at acceptance, evaluated against its pot's
// state entry in the next cycle, and its request (if any) then goes to the output
// register; the per-pot table is read-modified-written in that cycle. A sample
// with a request waits on a full, unread output register; one with no request
// never waits on the output side. The pot table is held in flip-flops and cleared
// at once by reset; pot indexes at or above POT_COUNT are dropped.
`include "pot_change_gate_to_cc_unit_macros.svh"

module pot_change_gate_to_cc_unit #(
    parameter int POT_COUNT = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pcg_stream_if.sink                      i_in,
    pcg_stream_if.source                    o_out,
    input  logic                            i_cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pcg_pkg::*;

    localparam int DEPTH = (POT_COUNT < MAX_POTS) ? POT_COUNT : MAX_POTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg        cfg;
    t_pot_state  st;
    t_state_wr   wr;
    t_eval       res;

    logic             r_s1_valid;
    t_in_item         r_s1_item;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             emit;
    logic             s1_fire;
    logic             in_ready;

    pcg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pcg_state_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (idx),
        .i_wr    (wr),
        .o_rd    (st)
    );

    pcg_eval u_eval (
        .i_item  (r_s1_item),
        .i_state (st),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Stage control: a request-free sample always retires
    always_comb begin
        in_range = 9'(r_s1_item.pot_index) < 9'(POT_COUNT);
        idx      = in_range ? r_s1_item.pot_index[IDX_W-1:0] : '0;
        emit     = in_range && res.emit;
        s1_fire  = r_s1_valid && (!emit || !r_out_valid || o_out.ready);
        in_ready = !r_s1_valid || s1_fire;
    end

    // State write-back for the retiring sample
    assign wr = '{sent_we:   s1_fire && emit,
                  move_we:   s1_fire && in_range && res.move,
                  raw:       r_s1_item.sample,
                  scaled:    res.scaled,
                  move_time: r_s1_item.now_ms};

    // Input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_s1_item <= i_in.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out_item <= '{out_index: r_s1_item.pot_index, cc_value: res.scaled,
                            out_channel: cfg.channel};
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // Checks
    `PCG_ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, s1_fire && emit, o_out.valid)
    `PCG_ASSERT_NOW(a_stall_needs_s1, i_clk, i_rst_n, !i_in.ready, r_s1_valid)
    `PCG_ASSERT_NOW(a_stall_only_on_full_out, i_clk, i_rst_n, r_s1_valid && !s1_fire, o_out.valid && !o_out.ready && emit)

endmodule

### tb/pcg_tb_pkg.sv
// Control-change predictor and request scoreboard for the pot change gate testbench.
package pcg_tb_pkg;
    import pcg_pkg::*;

    // Pot table depth the block is built with here
    localparam int POT_SLOTS = 32;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    class cc_request_scoreboard;
        // Register copies
        logic [9:0]  jitter_thr;
        logic [15:0] window_ms;
        logic [4:0]  channel;
        // Per-pot last sent values and last significant move
        logic [9:0]  sent_raw [POT_SLOTS];
        logic [6:0]  sent_cc [POT_SLOTS];
        logic [31:0] moved_at [POT_SLOTS];
        // Control changes still owed by the block, oldest first
        t_out_item   cc_expected_q[$];
        int          n_samples;
        int          n_changes;
        int          n_writes;
        int          n_errors;

        function new();
            jitter_thr = 10'd10;
            window_ms  = 16'd300;
            channel    = 5'd1;
            foreach (sent_raw[p]) begin
                sent_raw[p] = '0;
                sent_cc[p]  = '0;
                moved_at[p] = '0;
            end
        endfunction

        function int pending();
            return cc_expected_q.size();
        endfunction

        task report(string msg);
            if (n_errors < 40) $display("MISMATCH: %s", msg);
            n_errors++;
        endtask

        // Register write as the block sees it; unknown indexes are dropped
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_writes++;
            case (idx)
                CFG_THRESHOLD: jitter_thr = data[9:0];
                CFG_TIMEOUT:   window_ms  = data[15:0];
                CFG_CHANNEL:   channel    = data[4:0];
                default: ;
            endcase
        endfunction

        // Predict the control change (if any) for one accepted sample request
        function void note_request(t_in_item it);
            int          p;
            logic [6:0]  level;
            logic [9:0]  delta;
            logic [31:0] age;
            t_out_item   cc;
            n_samples++;
            p = int'(it.pot_index);
            if (p >= POT_SLOTS) return;
            level = 7'((int'(it.sample) * CC_FULL) / SAMPLE_FULL);
            delta = (it.sample >= sent_raw[p]) ? it.sample - sent_raw[p]
                                               : sent_raw[p] - it.sample;
            if (delta > jitter_thr) moved_at[p] = it.now_ms;
            // wrapping millisecond distance
            age = it.now_ms - moved_at[p];
            if (age < {16'd0, window_ms} && level != sent_cc[p]) begin
                sent_raw[p]     = it.sample;
                sent_cc[p]      = level;
                cc.out_index    = it.pot_index;
                cc.cc_value     = level;
                cc.out_channel  = channel;
                cc_expected_q.push_back(cc);
            end
        endfunction

        // Compare one delivered control change with the oldest prediction
        task check_result(t_out_item got);
            t_out_item want;
            n_changes++;
            if (cc_expected_q.size() == 0) begin
                report($sformatf("unexpected change pot %0d value %0d channel %0d",
                                 got.out_index, got.cc_value, got.out_channel));
                return;
            end
            want = cc_expected_q.pop_front();
            if (got.out_index !== want.out_index)
                report($sformatf("out_index got %0d want %0d",
                                 got.out_index, want.out_index));
            if (got.cc_value !== want.cc_value)
                report($sformatf("cc_value got %0d want %0d (pot %0d)",
                                 got.cc_value, want.cc_value, want.out_index));
            if (got.out_channel !== want.out_channel)
                report($sformatf("out_channel got %0d want %0d (pot %0d)",
                                 got.out_channel, want.out_channel, want.out_index));
        endtask

        task flush_leftovers();
            t_out_item want;
            while (cc_expected_q.size() != 0) begin
                want = cc_expected_q.pop_front();
                report($sformatf("missing change pot %0d value %0d channel %0d",
                                 want.out_index, want.cc_value, want.out_channel));
            end
        endtask
    endclass

endpackage

### tb/tb_top.sv
// Top-level testbench of the pot change gate: stimulus, handshake drivers and checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;
    import pcg_tb_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int BURST_ITEMS   = 40;
    localparam int HOLD_CYCLES   = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pcg_stream_if #(.T(t_in_item))  in_if ();
    pcg_stream_if #(.T(t_out_item)) out_if ();

    pot_change_gate_to_cc_unit #(.POT_COUNT(POT_SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cc_request_scoreboard sb = new();

    // Stimulus state: running millisecond clock and a level walker per pot
    logic [31:0] clock_ms;
    int          pot_level [POT_SLOTS];
    bit          tx_burst;
    bit          rx_free;
    int          rx_hold_req;
    bit          rx_holding;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #10ms;
        $display("Timeout: run did not drain in time");
        $display("Test completed with failures");
        $finish;
    end

    function automatic int tx_gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function automatic int rx_stall_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Offer one sample request and hold it until the block takes it
    task automatic send_request(t_in_item it, int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(it);
    endtask

    task automatic offer(logic [4:0] pot, logic [9:0] smp, logic [31:0] ms);
        t_in_item it;
        it.pot_index = pot;
        it.sample    = smp;
        it.now_ms    = ms;
        send_request(it, tx_gap_len());
    endtask

    // Stop offering, let every owed change arrive, then let the pipe empty
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_all(logic [15:0] thr, logic [15:0] tmo, logic [15:0] chan);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_TIMEOUT, tmo);
        cfg_write(CFG_CHANNEL, chan);
    endtask

    // Mostly pot motion with random content, some jitter, some stale and noise samples
    function automatic t_in_item random_request();
        t_in_item it;
        int       kind;
        int       lvl;
        kind = $urandom_range(99);
        // a few busy pots so motion windows overlap
        it.pot_index = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                : 5'($urandom_range(3));
        lvl = pot_level[it.pot_index];
        if (kind < 60) begin
            clock_ms += $urandom_range(20);
            lvl += int'($urandom_range(400)) - 200;
        end else if (kind < 85) begin
            clock_ms += $urandom_range(5);
            lvl += int'($urandom_range(24)) - 12;
        end else if (kind < 93) begin
            clock_ms += $urandom_range(70000, 200);
        end else begin
            clock_ms = $urandom();
            lvl = $urandom_range(1023);
        end
        if (lvl < 0) lvl = 0;
        if (lvl > SAMPLE_FULL) lvl = SAMPLE_FULL;
        pot_level[it.pot_index] = lvl;
        it.sample = 10'(lvl);
        it.now_ms = clock_ms;
        return it;
    endfunction

    // Delivered changes
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    // Result side: random stalls, free-running stretches and one long hold-off
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                out_if.ready <= 1'b0;
                rx_holding = 1'b1;
                repeat (rx_hold_req) @(posedge i_clk);
                rx_hold_req = 0;
                rx_holding  = 1'b0;
            end else if (rx_free) begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
                out_if.ready <= 1'b0;
                repeat (rx_stall_len()) @(posedge i_clk);
            end
        end
    end

    // Main sequence
    initial begin
        t_in_item it;
        int       guard;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        clock_ms    = '0;
        tx_burst    = 1'b0;
        rx_free     = 1'b0;
        rx_hold_req = 0;
        rx_holding  = 1'b0;
        foreach (pot_level[p]) pot_level[p] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: early timestamps, jitter, value extremes, timestamp wrap
        offer(5'd0, 10'd1023, 32'd5);
        offer(5'd1, 10'd5, 32'd10);
        offer(5'd1, 10'd9, 32'd20);
        offer(5'd2, 10'd9, 32'd400);
        offer(5'd31, 10'd1023, 32'hFFFF_FFFF);
        offer(5'd31, 10'd0, 32'd0);
        offer(5'd30, 10'd600, 32'hFFFF_FF00);
        offer(5'd30, 10'd605, 32'h0000_0010);
        offer(5'd0, 10'd1023, 32'd40);

        // Largest threshold and timeout, top channel
        wait_idle();
        cfg_all(16'hFFFF, 16'hFFFF, 16'd16);
        offer(5'd4, 10'd1023, 32'd1000);
        offer(5'd4, 10'd0, 32'd2000);

        // Zero timeout: nothing may come out; channel zero
        wait_idle();
        cfg_all(16'd0, 16'd0, 16'd0);
        offer(5'd5, 10'd512, 32'd50);
        offer(5'd5, 10'd1023, 32'd60);

        // One-millisecond window, channel 31, write to the spare index
        wait_idle();
        cfg_write(CFG_TIMEOUT, 16'd1);
        cfg_write(CFG_CHANNEL, 16'd31);
        cfg_write(CFG_IDX_SPARE, 16'hFFFF);
        offer(5'd6, 10'd300, 32'd70);
        offer(5'd6, 10'd300, 32'd70);
        offer(5'd6, 10'd301, 32'd71);

        // Channel out of MIDI range, window edge
        wait_idle();
        cfg_all(16'd10, 16'd300, 16'd17);
        offer(5'd7, 10'd1023, 32'h8000_0000);
        offer(5'd7, 10'd1020, 32'h8000_0001);
        offer(5'd7, 10'd1015, 32'h8000_012C);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: cfg_all(16'd10, 16'd300, 16'd1);
                1: cfg_all(16'd0, 16'd65535, 16'd16);
                2: cfg_all(16'd1023, 16'd5000, 16'd0);
                default: cfg_all({6'($urandom()), 10'($urandom_range(40))},
                                 16'($urandom_range(2000, 20)), 16'($urandom()));
            endcase
            tx_burst = (ph % 3 == 1);
            rx_free  = (ph % 3 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it = random_request();
                send_request(it, tx_burst ? 0 : tx_gap_len());
            end

            // Back-pressure: output held off while full-swing moves keep coming
            if (ph == 0) begin
                wait_idle();
                rx_hold_req = HOLD_CYCLES;
                while (!rx_holding) @(posedge i_clk);
                for (int k = 0; k < BURST_ITEMS; k++) begin
                    clock_ms += 1;
                    it.pot_index = 5'(8 + k % 8);
                    it.sample    = ((k / 8) % 2 == 0) ? 10'd1023 : 10'd0;
                    it.now_ms    = clock_ms;
                    send_request(it, 0);
                end
            end
        end

        // Drain
        in_if.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        $display("Summary: %0d pot samples sent, %0d control changes checked, %0d register writes",
                 sb.n_samples, sb.n_changes, sb.n_writes);
        $display("Covered threshold/timeout extremes, out-of-range channels and a stalled output");
        if (sb.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
